[hdl/assert_macros.svh]
// assertion macros used by the top level of the matrix inverse block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, ignored while reset is asserted
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also checked during reset
`define M3I_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg)
`define M3I_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/m3i_pkg.sv]
// types and constants of the 3x3 matrix inverse block
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 48;
	localparam int ADJ_W     = 32;
	localparam int ADJ_MAG_W = 31;
	localparam int DET_W     = 50;
	localparam int REM_W     = 48;
	localparam int NUM_W     = ADJ_MAG_W + FRAC_BITS;
	localparam int COF_LAT   = 4;
	localparam int LAT       = COF_LAT + NUM_W + 1;

	typedef logic signed [ADJ_W-1:0] adj_w_t;
	typedef logic signed [DET_W-1:0] det_w_t;

	// element indices (row*3+col) of a, b, c, d in adj = a*b - c*d
	typedef logic [3:0] idx_t;
	localparam idx_t COF_IDX [9][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	typedef struct packed {
		logic signed [IN_W-1:0] m00;
		logic signed [IN_W-1:0] m01;
		logic signed [IN_W-1:0] m02;
		logic signed [IN_W-1:0] m10;
		logic signed [IN_W-1:0] m11;
		logic signed [IN_W-1:0] m12;
		logic signed [IN_W-1:0] m20;
		logic signed [IN_W-1:0] m21;
		logic signed [IN_W-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] inv00;
		logic signed [OUT_W-1:0] inv01;
		logic signed [OUT_W-1:0] inv02;
		logic signed [OUT_W-1:0] inv10;
		logic signed [OUT_W-1:0] inv11;
		logic signed [OUT_W-1:0] inv12;
		logic signed [OUT_W-1:0] inv20;
		logic signed [OUT_W-1:0] inv21;
		logic signed [OUT_W-1:0] inv22;
		logic                    singular;
	} inv_t;
endpackage
`default_nettype wire

[hdl/matrix3x3_inverse.sv]
// top level of the 3x3 matrix inverse: cofactor pipeline, nine divider lanes, merge
//
//   channel  valid      stall      word
//   input    mat_valid  mat_stall  mat (m3i_pkg::mat_t)
//   output   inv_valid  inv_stall  inv (m3i_pkg::inv_t)
//
// one word in per cycle while mat_stall is low, one result per word
// most of the pipeline lies in the divider lanes, which resolve one quotient bit per stage
// the whole pipeline advances together; it holds only when a result waits in
// the output register and inv_stall is high, and then mat_stall is raised
// reset clears the valid bits of the pipeline and the output register only
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module matrix3x3_inverse (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           mat_valid,
	output logic                mat_stall,
	input  wire m3i_pkg::mat_t  mat,
	output logic                inv_valid,
	input  wire logic           inv_stall,
	output m3i_pkg::inv_t       inv
);
	localparam int LAT = m3i_pkg::LAT;
	localparam int DL  = m3i_pkg::NUM_W + 1;

	logic            en;
	logic [LAT-1:0]  valid_s;
	logic [DL-1:0]   sing_s;
	m3i_pkg::adj_w_t adj [9];
	m3i_pkg::det_w_t det;
	logic [m3i_pkg::NUM_W-1:0] quo [9];
	logic            neg [9];
	logic signed [m3i_pkg::OUT_W-1:0] val [9];
	logic            out_valid_q;
	m3i_pkg::inv_t   out_q;

	// move whenever the output register is free or being emptied
	assign en        = !out_valid_q || !inv_stall;
	assign mat_stall = !en;

	m3i_cofactor u_cof (
		.clk (clk),
		.en  (en),
		.mat (mat),
		.adj (adj),
		.det (det)
	);

	for (genvar k = 0; k < 9; k++) begin : g_lane
		logic signed [m3i_pkg::OUT_W-1:0] mag;
		m3i_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.adj (adj[k]),
			.det (det),
			.quo (quo[k]),
			.neg (neg[k])
		);
		// merge: restore sign, force zero when no inverse exists
		always_comb begin
			mag    = m3i_pkg::OUT_W'(quo[k]);
			val[k] = sing_s[DL-1] ? '0 : (neg[k] ? -mag : mag);
		end
	end

	// valid bits follow the words through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s     <= {valid_s[LAT-2:0], mat_valid};
			out_valid_q <= valid_s[LAT-1];
		end
	end

	// singular flag travels beside the divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			sing_s <= {sing_s[DL-2:0], (det == '0)};
			out_q  <= '{inv00: val[0], inv01: val[1], inv02: val[2],
				inv10: val[3], inv11: val[4], inv12: val[5],
				inv20: val[6], inv21: val[7], inv22: val[8],
				singular: sing_s[DL-1]};
		end
	end

	assign inv_valid = out_valid_q;
	assign inv       = out_q;

	`M3I_ASSERT(a_sing_zero, clk, arst_n, inv_valid && inv.singular |-> inv.inv00 == '0 && inv.inv11 == '0 && inv.inv22 == '0 && inv.inv01 == '0 && inv.inv12 == '0, "singular word carries nonzero entries")
	`M3I_ASSERT(a_drop_taken, clk, arst_n, $fell(inv_valid) |-> $past(!inv_stall), "result dropped before it was taken")
	`M3I_ASSERT(a_freeze, clk, arst_n, mat_stall |=> $stable(valid_s), "pipeline moved while output held")
	`M3I_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !inv_valid, "output valid after a reset edge")
endmodule
`default_nettype wire

[hdl/m3i_cofactor.sv]
// adjugate and determinant pipeline, four stages
`timescale 1ns / 1ps
`default_nettype none
module m3i_cofactor (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire m3i_pkg::mat_t   mat,
	output m3i_pkg::adj_w_t      adj [9],
	output m3i_pkg::det_w_t      det
);
	logic signed [m3i_pkg::IN_W-1:0] a [9];
	logic signed [m3i_pkg::ADJ_W-1:0] p_s1 [9];
	logic signed [m3i_pkg::ADJ_W-1:0] q_s1 [9];
	m3i_pkg::adj_w_t adj_s2 [9];
	m3i_pkg::adj_w_t adj_s3 [9];
	m3i_pkg::adj_w_t adj_s4 [9];
	logic signed [m3i_pkg::IN_W-1:0] r0_s1 [3];
	logic signed [m3i_pkg::IN_W-1:0] r0_s2 [3];
	m3i_pkg::det_w_t t_s3 [3];
	m3i_pkg::det_w_t det_s4;

	assign a[0] = mat.m00;
	assign a[1] = mat.m01;
	assign a[2] = mat.m02;
	assign a[3] = mat.m10;
	assign a[4] = mat.m11;
	assign a[5] = mat.m12;
	assign a[6] = mat.m20;
	assign a[7] = mat.m21;
	assign a[8] = mat.m22;

	for (genvar k = 0; k < 9; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				p_s1[k]   <= m3i_pkg::ADJ_W'(a[m3i_pkg::COF_IDX[k][0]])
					* m3i_pkg::ADJ_W'(a[m3i_pkg::COF_IDX[k][1]]);
				q_s1[k]   <= m3i_pkg::ADJ_W'(a[m3i_pkg::COF_IDX[k][2]])
					* m3i_pkg::ADJ_W'(a[m3i_pkg::COF_IDX[k][3]]);
				adj_s2[k] <= p_s1[k] - q_s1[k];
				adj_s3[k] <= adj_s2[k];
				adj_s4[k] <= adj_s3[k];
			end
		end
		assign adj[k] = adj_s4[k];
	end

	// row 0 against column 0 of the adjugate gives the determinant
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				r0_s1[j] <= a[j];
				r0_s2[j] <= r0_s1[j];
				t_s3[j]  <= m3i_pkg::DET_W'(r0_s2[j]) * m3i_pkg::DET_W'(adj_s2[3*j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= t_s3[0] + t_s3[1] + t_s3[2];
		end
	end

	assign det = det_s4;
endmodule
`default_nettype wire

[hdl/m3i_div_lane.sv]
// one divider lane: restoring division of magnitudes, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module m3i_div_lane (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire m3i_pkg::adj_w_t               adj,
	input  wire m3i_pkg::det_w_t               det,
	output logic [m3i_pkg::NUM_W-1:0]          quo,
	output logic                               neg
);
	localparam int NW = m3i_pkg::NUM_W;
	localparam int RW = m3i_pkg::REM_W;

	logic [RW-1:0] rem_s [NW+1];
	logic [NW-1:0] nq_s  [NW+1];
	logic [RW-1:0] den_s [NW+1];
	logic          neg_s [NW+1];
	m3i_pkg::adj_w_t adj_mag;
	m3i_pkg::det_w_t det_mag;

	assign adj_mag = adj[m3i_pkg::ADJ_W-1] ? -adj : adj;
	assign det_mag = det[m3i_pkg::DET_W-1] ? -det : det;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= NW'(adj_mag[m3i_pkg::ADJ_MAG_W-1:0]) << m3i_pkg::FRAC_BITS;
			den_s[0] <= det_mag[RW-1:0];
			neg_s[0] <= adj[m3i_pkg::ADJ_W-1] ^ det[m3i_pkg::DET_W-1];
		end
	end

	// numerator bits shift out at the top, quotient bits shift in at the bottom
	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [RW:0] trial;
		logic [RW:0] diff;
		logic        qbit;
		always_comb begin
			trial = {rem_s[k], nq_s[k][NW-1]};
			diff  = trial - {1'b0, den_s[k]};
			qbit  = (trial >= {1'b0, den_s[k]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= qbit ? diff[RW-1:0] : trial[RW-1:0];
				nq_s[k+1]  <= {nq_s[k][NW-2:0], qbit};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo = nq_s[NW];
	assign neg = neg_s[NW];
endmodule
`default_nettype wire

[test/tb_matrix3x3_inverse.sv]
// testbench for the 3x3 matrix inverse block: directed and random matrices checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_matrix3x3_inverse;
	// pipeline depth of the top level; the margin is added where it is waited on
	localparam int PIPE_DEPTH = 53;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	m3i_pkg::mat_t mat = '0;
	logic inv_valid;
	logic inv_stall = 1'b0;
	m3i_pkg::inv_t inv;

	// expected inverses, oldest first
	m3i_pkg::inv_t inverse_queue[$];
	int errors = 0;
	int cycles = 0;
	// stall behavior of the result side: 0 none, 1 random gaps
	bit stall_random = 1'b0;

	always #5 clk = ~clk;

	matrix3x3_inverse uut (
		.clk(clk),
		.arst_n(arst_n),
		.mat_valid(mat_valid),
		.mat_stall(mat_stall),
		.mat(mat),
		.inv_valid(inv_valid),
		.inv_stall(inv_stall),
		.inv(inv)
	);

	// exact inverse in fixed point: adjugate times 2^FRAC_BITS over determinant
	function automatic m3i_pkg::inv_t predict_inverse(m3i_pkg::mat_t m);
		longint e[9];
		longint adj[9];
		longint det;
		longint q;
		m3i_pkg::inv_t r;
		e[0] = m.m00; e[1] = m.m01; e[2] = m.m02;
		e[3] = m.m10; e[4] = m.m11; e[5] = m.m12;
		e[6] = m.m20; e[7] = m.m21; e[8] = m.m22;
		adj[0] = e[4] * e[8] - e[5] * e[7];
		adj[1] = e[2] * e[7] - e[1] * e[8];
		adj[2] = e[1] * e[5] - e[2] * e[4];
		adj[3] = e[5] * e[6] - e[3] * e[8];
		adj[4] = e[0] * e[8] - e[2] * e[6];
		adj[5] = e[2] * e[3] - e[0] * e[5];
		adj[6] = e[3] * e[7] - e[4] * e[6];
		adj[7] = e[1] * e[6] - e[0] * e[7];
		adj[8] = e[0] * e[4] - e[1] * e[3];
		// expand along row 0
		det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int i = 0; i < 9; i++) begin
			// signed division truncates toward zero
			q = (adj[i] * (longint'(1) <<< m3i_pkg::FRAC_BITS)) / det;
			case (i)
				0: r.inv00 = q[m3i_pkg::OUT_W-1:0];
				1: r.inv01 = q[m3i_pkg::OUT_W-1:0];
				2: r.inv02 = q[m3i_pkg::OUT_W-1:0];
				3: r.inv10 = q[m3i_pkg::OUT_W-1:0];
				4: r.inv11 = q[m3i_pkg::OUT_W-1:0];
				5: r.inv12 = q[m3i_pkg::OUT_W-1:0];
				6: r.inv20 = q[m3i_pkg::OUT_W-1:0];
				7: r.inv21 = q[m3i_pkg::OUT_W-1:0];
				default: r.inv22 = q[m3i_pkg::OUT_W-1:0];
			endcase
		end
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// send one word, wait for acceptance, optionally idle afterwards
	task automatic send_matrix(m3i_pkg::mat_t m, bit with_gaps);
		int gap;
		mat <= m;
		mat_valid <= 1'b1;
		@(posedge clk);
		while (mat_stall) @(posedge clk);
		inverse_queue.push_back(predict_inverse(m));
		gap = with_gaps ? gap_length() : 0;
		if (gap > 0) begin
			mat_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drop_valid();
		mat_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every expected inverse has come back
	task automatic drain();
		while (inverse_queue.size() != 0) @(posedge clk);
	endtask

	function automatic logic [m3i_pkg::IN_W-1:0] random_entry();
		int p;
		p = $urandom_range(0, 9);
		case (p)
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3, 4: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic m3i_pkg::mat_t random_matrix();
		m3i_pkg::mat_t m;
		int p;
		m = '0;
		m.m00 = random_entry(); m.m01 = random_entry(); m.m02 = random_entry();
		m.m10 = random_entry(); m.m11 = random_entry(); m.m12 = random_entry();
		m.m20 = random_entry(); m.m21 = random_entry(); m.m22 = random_entry();
		p = $urandom_range(0, 9);
		// force singular matrices now and then: a repeated row, a zero row or a repeated column
		if (p == 0) begin
			m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
		end else if (p == 1) begin
			m.m10 = '0; m.m11 = '0; m.m12 = '0;
		end else if (p == 2) begin
			m.m02 = m.m01; m.m12 = m.m11; m.m22 = m.m21;
		end
		return m;
	endfunction

	function automatic m3i_pkg::mat_t diag(logic [m3i_pkg::IN_W-1:0] a,
		logic [m3i_pkg::IN_W-1:0] b, logic [m3i_pkg::IN_W-1:0] c);
		m3i_pkg::mat_t m;
		m = '0;
		m.m00 = a; m.m11 = b; m.m22 = c;
		return m;
	endfunction

	// identity, scaled diagonals, extremes, sign mixes and singular cases
	task automatic test_directed();
		m3i_pkg::mat_t m;
		send_matrix(diag(16'd1, 16'd1, 16'd1), 1'b0);
		send_matrix(diag(16'd2, 16'd4, 16'hfff8), 1'b0);
		send_matrix(diag(16'd3, 16'd7, 16'd11), 1'b0);
		send_matrix(diag(16'h7fff, 16'h7fff, 16'h7fff), 1'b0);
		send_matrix(diag(16'h8000, 16'h8000, 16'h8000), 1'b0);
		send_matrix(diag(16'h8000, 16'h7fff, 16'd1), 1'b0);
		send_matrix(diag(16'hffff, 16'd1, 16'hffff), 1'b0);
		// all zero and all equal: singular
		send_matrix('0, 1'b0);
		send_matrix({9{16'h7fff}}, 1'b0);
		send_matrix({9{16'h8000}}, 1'b0);
		send_matrix({9{16'hffff}}, 1'b0);
		// alternating extremes
		send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'h7fff, 16'h7fff}, 1'b0);
		send_matrix({16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h8000, 16'h7fff}, 1'b0);
		// permutation matrix, determinant -1
		m = '0; m.m01 = 16'd1; m.m10 = 16'd1; m.m22 = 16'd1;
		send_matrix(m, 1'b0);
		// general small matrices with fractional and negative entries in the inverse
		send_matrix({16'd2, 16'd1, 16'd0, 16'd1, 16'd3, 16'd1, 16'd0, 16'd1, 16'd4}, 1'b0);
		send_matrix({16'hfffd, 16'd5, 16'd7, 16'd2, 16'hfff9, 16'd1, 16'd9, 16'd4,
			16'hfffe}, 1'b0);
		// huge determinant, tiny inverse entries
		send_matrix({16'h7fff, 16'd1, 16'd0, 16'd0, 16'h7fff, 16'd1, 16'd1, 16'd0,
			16'h7fff}, 1'b0);
		// rank two with nonzero entries
		send_matrix({16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9}, 1'b0);
		drop_valid();
		drain();
	endtask

	// back-to-back words into a result side that never stalls
	task automatic test_streaming();
		stall_random = 1'b0;
		repeat (100) send_matrix(random_matrix(), 1'b0);
		drop_valid();
		drain();
	endtask

	// random gaps on both sides, with one full drain between the two batches
	task automatic test_random_traffic();
		stall_random = 1'b1;
		repeat (250) send_matrix(random_matrix(), 1'b1);
		// hold off until every result is back
		drop_valid();
		drain();
		repeat (300) send_matrix(random_matrix(), 1'b1);
		drop_valid();
		drain();
		stall_random = 1'b0;
	endtask

	// result side stall, driven at the clock edge
	always @(posedge clk) begin
		if (!stall_random) begin
			inv_stall <= 1'b0;
		end else if (inv_stall) begin
			inv_stall <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 30) != 0);
		end else begin
			inv_stall <= ($urandom_range(0, 99) < 20);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		m3i_pkg::inv_t want;
		cycles <= cycles + 1;
		if (arst_n && inv_valid && !inv_stall) begin
			if (inverse_queue.size() == 0) begin
				$display("%0t: unexpected word %h", $time, inv);
				errors <= errors + 1;
			end else begin
				want = inverse_queue.pop_front();
				if (want !== inv) begin
					errors <= errors + 1;
					$display("%0t: mismatch expected %h actual %h", $time, want, inv);
					if (want.singular !== inv.singular)
						$display("%0t:  singular expected %b actual %b", $time,
							want.singular, inv.singular);
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_streaming();
		test_random_traffic();
		// let any stray word come out
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (errors == 0 && inverse_queue.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/m3i_pkg.sv
hdl/m3i_cofactor.sv
hdl/m3i_div_lane.sv
hdl/matrix3x3_inverse.sv
test/tb_matrix3x3_inverse.sv
